// ----- src/rcld_pkg.sv -----
// shared constants, types and the brightness curve rom builder for the rc pulse led dimmer
`default_nettype none

package rcld_pkg;

  // fixed widths of the result side
  localparam int DUTY_BITS = 8;
  localparam int OUT_W     = 5 * DUTY_BITS;
  localparam int USER_W    = 3;

  // pulse widths are compared after zero extension to this width
  localparam int WIDE_BITS = 16;

  // target selector thresholds, worked out from floor((w-1000)*3/1000)
  localparam logic [WIDE_BITS-1:0] TARGET_ONE_MIN = 16'd1334;
  localparam logic [WIDE_BITS-1:0] TARGET_TWO_MIN = 16'd1667;

  // power gate, strictly above
  localparam logic [WIDE_BITS-1:0] POWER_MIN = 16'd1500;

  // brightness stick window
  localparam logic [WIDE_BITS-1:0] LEVEL_BASE_WIDTH = 16'd1000;
  localparam logic [WIDE_BITS-1:0] LEVEL_TOP_WIDTH  = 16'd2000;
  localparam int                   LEVEL_STEPS      = 1000;
  localparam int                   LEVEL_FLOOR      = 40;
  localparam int                   LEVEL_SPAN       = 215;

  // hue stick window, top of window wraps to red
  localparam logic [WIDE_BITS-1:0] HUE_BASE_WIDTH = 16'd1200;
  localparam logic [WIDE_BITS-1:0] HUE_TOP_WIDTH  = 16'd2000;

  // 3277 / 16384 approximates 1/5, exact floor for values below 16384
  localparam logic [11:0] RECIP_FIVE = 12'd3277;

  // target codes
  localparam logic [1:0] TGT_RGB      = 2'd0;
  localparam logic [1:0] TGT_LAMP_ONE = 2'd1;
  localparam logic [1:0] TGT_LAMP_TWO = 2'd2;

  // 60 degree hue sectors
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;
  localparam logic [2:0] SEC_MAG_RED = 3'd5;

  // one brightness entry per stick step
  typedef logic [LEVEL_STEPS:0][DUTY_BITS-1:0] level_rom_t;

  // b^5 * 1000^6 <= 215^5 * n^6, both sides divided by 5^5
  function automatic logic level_fits(input logic [7:0] b, input logic [9:0] n);
    logic [127:0] bb;
    logic [127:0] nn;
    logic [127:0] lhs;
    logic [127:0] rhs;
    bb  = 128'(b);
    nn  = 128'(n);
    lhs = bb * bb * bb * bb * bb * 128'(64'd320000000000000);
    rhs = nn * nn * nn * nn * nn * nn * 128'(32'd147008443);
    return lhs <= rhs;
  endfunction

  // curve is monotonic, so the fitted value only ever climbs with n
  function automatic level_rom_t build_level_rom();
    level_rom_t  rom;
    int unsigned b;
    b = 0;
    for (int n = 0; n <= LEVEL_STEPS; n++) begin
      while (b < LEVEL_SPAN && level_fits(8'(b + 1), 10'(n))) begin
        b++;
      end
      rom[n] = 8'(LEVEL_FLOOR + b);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ----- src/rc_pulse_to_led_dimmer.sv -----
// rc pulse widths to rgb and single led pwm duties with gamma brightness and hue
// an item passes the hue, ramp, multiply and finish steps before it shows on m_tvalid
// a new item waits until the last one is through; the bit-serial ramp multiplier has 8 steps
// the result sits in an output register, so the next item is taken while it waits
// reset: rst synchronous active high, clears the held duties to zero and empties the output
// the brightness curve is a constant rom built at elaboration, so no clearing pass is needed
`default_nettype none

module rc_pulse_to_led_dimmer #(
  parameter  int PULSE_BITS = 12,
  localparam int IN_W       = ((4 * PULSE_BITS + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // target_width, level_width, hue_width, power_width, zero padded
  input  logic [IN_W-1:0]            s_tdata,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // red_duty, green_duty, blue_duty, lamp_one_duty, lamp_two_duty
  output logic [rcld_pkg::OUT_W-1:0] m_tdata,
  // chosen_target, power_on
  output logic [rcld_pkg::USER_W-1:0] m_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a transaction
  localparam logic [2:0] ST_HUE  = 3'd1;  // rom read and hue angle
  localparam logic [2:0] ST_RAMP = 3'd2;  // sector and ramp component
  localparam logic [2:0] ST_MUL  = 3'd3;  // ramp times brightness, one bit a cycle
  localparam logic [2:0] ST_DONE = 3'd4;  // scale, update held duties, load output

  localparam rcld_pkg::level_rom_t LEVEL_ROM = rcld_pkg::build_level_rom();

  logic [2:0] state;

  // captured item, already reduced to what the later steps need
  logic [1:0] tgt;
  logic       pwr;
  logic [9:0] lvl_idx;
  logic [9:0] hue_off;

  // working registers
  logic [7:0]  level;
  logic [8:0]  hue;
  logic [2:0]  sector;
  logic [15:0] prod;      // upper half accumulates, lower half shifts out the multiplier
  logic [2:0]  bit_cnt;

  // held duties
  logic [7:0] held_red;
  logic [7:0] held_green;
  logic [7:0] held_blue;
  logic [7:0] held_lamp_one;
  logic [7:0] held_lamp_two;

  // ---------------------------------------------------------------- input decode
  logic [15:0] tw_w;
  logic [15:0] lw_w;
  logic [15:0] hw_w;
  logic [15:0] pw_w;
  logic [1:0]  tgt_in;
  logic [9:0]  lvl_idx_in;
  logic [9:0]  hue_off_in;
  logic        s_fire;

  assign tw_w = 16'(s_tdata[0*PULSE_BITS +: PULSE_BITS]);
  assign lw_w = 16'(s_tdata[1*PULSE_BITS +: PULSE_BITS]);
  assign hw_w = 16'(s_tdata[2*PULSE_BITS +: PULSE_BITS]);
  assign pw_w = 16'(s_tdata[3*PULSE_BITS +: PULSE_BITS]);

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // target thirds of the 1000..2000 window, short pulses pick rgb
  always_comb begin
    priority if (tw_w >= rcld_pkg::TARGET_TWO_MIN) begin
      tgt_in = rcld_pkg::TGT_LAMP_TWO;
    end else if (tw_w >= rcld_pkg::TARGET_ONE_MIN) begin
      tgt_in = rcld_pkg::TGT_LAMP_ONE;
    end else begin
      tgt_in = rcld_pkg::TGT_RGB;
    end
  end

  // brightness step 0..1000, saturating at both ends
  always_comb begin
    priority if (lw_w <= rcld_pkg::LEVEL_BASE_WIDTH) begin
      lvl_idx_in = '0;
    end else if (lw_w >= rcld_pkg::LEVEL_TOP_WIDTH) begin
      lvl_idx_in = 10'(rcld_pkg::LEVEL_STEPS);
    end else begin
      lvl_idx_in = 10'(lw_w - rcld_pkg::LEVEL_BASE_WIDTH);
    end
  end

  // hue offset 0..799; the top of the window lands on 360 degrees, same as zero
  always_comb begin
    if (hw_w <= rcld_pkg::HUE_BASE_WIDTH || hw_w >= rcld_pkg::HUE_TOP_WIDTH) begin
      hue_off_in = '0;
    end else begin
      hue_off_in = 10'(hw_w - rcld_pkg::HUE_BASE_WIDTH);
    end
  end

  // ---------------------------------------------------------------- hue angle
  // degrees = floor(off * 9 / 20): multiply by 9, drop two bits, then divide by 5
  logic [12:0] hue_x9;
  logic [22:0] hue_recip;
  logic [8:0]  hue_in;

  assign hue_x9    = 13'({hue_off, 3'b000}) + 13'(hue_off);
  assign hue_recip = 23'(hue_x9[12:2]) * 23'(rcld_pkg::RECIP_FIVE);
  assign hue_in    = hue_recip[22:14];

  // ---------------------------------------------------------------- ramp component
  logic [2:0] sector_in;
  logic [6:0] hue_mod;     // hue mod 120
  logic [5:0] ramp_k;      // distance from the nearest primary, 0..60
  logic [9:0] ramp_k17;
  logic [7:0] ramp_x;      // round(k * 255 / 60), halves up

  always_comb begin
    priority if (hue >= 9'd300) begin
      sector_in = rcld_pkg::SEC_MAG_RED;
    end else if (hue >= 9'd240) begin
      sector_in = rcld_pkg::SEC_BLU_MAG;
    end else if (hue >= 9'd180) begin
      sector_in = rcld_pkg::SEC_CYN_BLU;
    end else if (hue >= 9'd120) begin
      sector_in = rcld_pkg::SEC_GRN_CYN;
    end else if (hue >= 9'd60) begin
      sector_in = rcld_pkg::SEC_YEL_GRN;
    end else begin
      sector_in = rcld_pkg::SEC_RED_YEL;
    end
  end

  always_comb begin
    priority if (hue >= 9'd240) begin
      hue_mod = 7'(hue - 9'd240);
    end else if (hue >= 9'd120) begin
      hue_mod = 7'(hue - 9'd120);
    end else begin
      hue_mod = 7'(hue);
    end
  end

  assign ramp_k   = (hue_mod >= 7'd60) ? 6'(7'd120 - hue_mod) : 6'(hue_mod);
  assign ramp_k17 = 10'({ramp_k, 4'b0000}) + 10'(ramp_k) + 10'd2;
  assign ramp_x   = ramp_k17[9:2];

  // ---------------------------------------------------------------- serial multiply
  // shift-add, lsb of the multiplier first, only a 9 bit adder
  logic [8:0] mul_sum;

  assign mul_sum = 9'(prod[15:8]) + (prod[0] ? 9'(level) : 9'd0);

  // ---------------------------------------------------------------- scale and update
  logic [15:0] scale_sum;
  logic [7:0]  ramp_scaled;   // floor(ramp * level / 255)
  logic [7:0]  red_c;
  logic [7:0]  green_c;
  logic [7:0]  blue_c;
  logic [7:0]  red_next;
  logic [7:0]  green_next;
  logic [7:0]  blue_next;
  logic [7:0]  lamp_one_next;
  logic [7:0]  lamp_two_next;
  logic        out_free;
  logic        done_fire;

  // divide by 255 as (p + p/256 + 1) / 256, exact for any product of two 8 bit values
  assign scale_sum   = prod + 16'(prod[15:8]) + 16'd1;
  assign ramp_scaled = scale_sum[15:8];

  // a full component scales to the brightness itself
  always_comb begin
    unique case (sector)
      rcld_pkg::SEC_RED_YEL: begin
        red_c = level;       green_c = ramp_scaled; blue_c = '0;
      end
      rcld_pkg::SEC_YEL_GRN: begin
        red_c = ramp_scaled; green_c = level;       blue_c = '0;
      end
      rcld_pkg::SEC_GRN_CYN: begin
        red_c = '0;          green_c = level;       blue_c = ramp_scaled;
      end
      rcld_pkg::SEC_CYN_BLU: begin
        red_c = '0;          green_c = ramp_scaled; blue_c = level;
      end
      rcld_pkg::SEC_BLU_MAG: begin
        red_c = ramp_scaled; green_c = '0;          blue_c = level;
      end
      rcld_pkg::SEC_MAG_RED: begin
        red_c = level;       green_c = '0;          blue_c = ramp_scaled;
      end
      default: begin
        red_c = '0;          green_c = '0;          blue_c = '0;
      end
    endcase
  end

  // only the selected target moves, power off still updates it
  assign red_next      = (tgt == rcld_pkg::TGT_RGB) ? red_c : held_red;
  assign green_next    = (tgt == rcld_pkg::TGT_RGB) ? green_c : held_green;
  assign blue_next     = (tgt == rcld_pkg::TGT_RGB) ? blue_c : held_blue;
  assign lamp_one_next = (tgt == rcld_pkg::TGT_LAMP_ONE) ? level : held_lamp_one;
  assign lamp_two_next = (tgt == rcld_pkg::TGT_LAMP_TWO) ? level : held_lamp_two;

  // finish only once the output register is empty or being drained
  assign out_free  = !m_tvalid || m_tready;
  assign done_fire = (state == ST_DONE) && out_free;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      held_red      <= '0;
      held_green    <= '0;
      held_blue     <= '0;
      held_lamp_one <= '0;
      held_lamp_two <= '0;
    end else begin
      if (done_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state <= ST_HUE;
          end
        end
        ST_HUE: begin
          state <= ST_RAMP;
        end
        ST_RAMP: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (bit_cnt == 3'd7) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state         <= ST_IDLE;
            held_red      <= red_next;
            held_green    <= green_next;
            held_blue     <= blue_next;
            held_lamp_one <= lamp_one_next;
            held_lamp_two <= lamp_two_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (s_fire) begin
      tgt     <= tgt_in;
      pwr     <= (pw_w > rcld_pkg::POWER_MIN);
      lvl_idx <= lvl_idx_in;
      hue_off <= hue_off_in;
    end

    if (state == ST_HUE) begin
      level <= LEVEL_ROM[lvl_idx];
      hue   <= hue_in;
    end

    if (state == ST_RAMP) begin
      sector  <= sector_in;
      prod    <= {8'h00, ramp_x};
      bit_cnt <= '0;
    end

    if (state == ST_MUL) begin
      prod    <= {mul_sum, prod[7:1]};
      bit_cnt <= bit_cnt + 3'd1;
    end

    if (done_fire) begin
      m_tdata <= pwr ? {lamp_two_next, lamp_one_next, blue_next, green_next, red_next}
                     : '0;
      m_tuser <= {pwr, tgt};
    end
  end

  // ---------------------------------------------------------------- assertions
  // duties are all zero whenever the result says power is off
  a_power_off_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> m_tdata == '0)
    else $error("nonzero duty with power off");

  // the target code never goes past the second single led
  a_target_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[1:0] <= rcld_pkg::TGT_LAMP_TWO)
    else $error("illegal chosen target");

  // the finishing step is reached only through the full multiply
  a_done_after_mul: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> $past(state) == ST_MUL || $past(state) == ST_DONE)
    else $error("finish step entered without multiply");

  // a multiply always leaves after its eighth bit
  a_mul_length: assert property (@(posedge clk) disable iff (rst)
    state == ST_RAMP |=> ##8 state == ST_DONE)
    else $error("multiply did not take eight cycles");

endmodule

`default_nettype wire
